// ----- hw/rtl/thd_pkg.sv -----
// ----------------------------------------------------------------------------
// thd_pkg
// Shared types and constants of the tile Huffman tree decoder.
// ----------------------------------------------------------------------------
package thd_pkg;

   // default geometry
   localparam int CodebookDepthDef = 256;
   localparam int TileEdgeDef      = 64;

   // codebook entry layout: branch flag, far flag, 17-bit jump or colour
   localparam int EntryW    = 19;
   localparam int JumpW     = 17;
   localparam int EntBranch = 18;
   localparam int EntFar    = 17;

   // field widths
   localparam int ByteW   = 8;
   localparam int ColourW = 7;
   localparam int RepW    = 13;
   localparam int ShiftW  = 3;
   localparam int CountW  = 9;

   localparam logic [CountW-1:0] CountMax   = '1;
   localparam logic [ShiftW-1:0] ShiftMax   = 3'd6;
   localparam logic [ByteW-1:0]  FarMarker  = 8'd128;
   localparam logic [17:0]       FarBase    = 18'd65539;
   localparam logic [8:0]        NearBase   = 9'd257;

   typedef enum logic [1:0] {
      PH_LOAD,
      PH_DECODE,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_FAR,
      SQ_WALK
   } seq_type;

   typedef enum logic [1:0] {
      FP_NONE = 2'd0,
      FP_HIGH = 2'd1,
      FP_LOW  = 2'd2
   } far_pend_type;

   // one queued request
   typedef struct packed {
      logic [ByteW-1:0] tile_byte;
      logic             first_of_tile;
   } req_item_type;

endpackage

// ----- hw/rtl/tile_huffman_tree_decoder.sv -----
// Flow: a request first passes through the registered request queue; a codebook request
// then writes its entry (a far branch adds two colour-0 slots); a data request is taken
// from the queue, then makes one codebook memory read per code bit and a last leaf check.
// A new data request is taken only once the dependent read-and-step loop on the single
// codebook memory read port is done; up to one response per cycle while rsp_ready is high.
// Reset: synchronous, active high; clears control state, the codebook memory is not cleared.
// ----------------------------------------------------------------------------
// tile_huffman_tree_decoder
// Top level: request queue in front, codebook load and walk engine behind.
// ----------------------------------------------------------------------------
module tile_huffman_tree_decoder
   import thd_pkg::*;
#(
   parameter int CODEBOOK_DEPTH = CodebookDepthDef,
   parameter int TILE_EDGE      = TileEdgeDef
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ByteW-1:0]   req_tile_byte,
   input  logic               req_first_of_tile,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ColourW-1:0] rsp_colour_index,
   output logic [RepW-1:0]    rsp_repeat_count,
   output logic               rsp_last_of_tile,
   output logic               rsp_codebook_overflow,
   input  logic               csr_wr_en,
   input  logic [ShiftW-1:0]  csr_wr_data
);

   logic         q_valid;
   logic         q_pop;
   req_item_type q_item;

   // request queue
   thd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_tile_byte     (req_tile_byte),
      .req_first_of_tile (req_first_of_tile),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   // decode engine
   thd_back #(
      .CODEBOOK_DEPTH (CODEBOOK_DEPTH),
      .TILE_EDGE      (TILE_EDGE)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .q_valid               (q_valid),
      .q_item                (q_item),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_colour_index      (rsp_colour_index),
      .rsp_repeat_count      (rsp_repeat_count),
      .rsp_last_of_tile      (rsp_last_of_tile),
      .rsp_codebook_overflow (rsp_codebook_overflow)
   );

endmodule

// ----- hw/rtl/thd_front.sv -----
// ----------------------------------------------------------------------------
// thd_front
// Request intake: takes requests and holds them in a two-entry queue that
// decouples the input channel from the decode engine.
// ----------------------------------------------------------------------------
module thd_front
   import thd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ByteW-1:0]   req_tile_byte,
   input  logic               req_first_of_tile,
   output logic               q_valid,
   output req_item_type       q_item,
   input  logic               q_pop
);

   req_item_type slot_ff [2];
   logic         rd_ptr_ff, rd_ptr_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;

   // queue control
   always_comb begin
      push      = req_valid && req_ready;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{tile_byte: req_tile_byte, first_of_tile: req_first_of_tile};
      end
   end

endmodule

// ----- hw/rtl/thd_back.sv -----
// ----------------------------------------------------------------------------
// thd_back
// Decode engine: loads the codebook memory, walks it one code bit per cycle
// unless a leaf waits on a full response stage, and drives the registered response stage.
// ----------------------------------------------------------------------------
module thd_back
   import thd_pkg::*;
#(
   parameter int CODEBOOK_DEPTH = CodebookDepthDef,
   parameter int TILE_EDGE      = TileEdgeDef
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [ShiftW-1:0]  csr_wr_data,
   input  logic               q_valid,
   input  req_item_type       q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ColourW-1:0] rsp_colour_index,
   output logic [RepW-1:0]    rsp_repeat_count,
   output logic               rsp_last_of_tile,
   output logic               rsp_codebook_overflow
);

   localparam int PtrW   = $clog2(CODEBOOK_DEPTH);
   localparam int LenW   = $clog2(CODEBOOK_DEPTH + 1);
   localparam int PixMax = TILE_EDGE * TILE_EDGE;
   localparam int PixW   = $clog2(PixMax + 1);
   localparam logic [LenW-1:0] DepthLen = LenW'(CODEBOOK_DEPTH);

   // codebook memory
   logic [EntryW-1:0] mem [CODEBOOK_DEPTH];
   logic [EntryW-1:0] rdata_ff;
   logic              wr_en, rd_en;
   logic [PtrW-1:0]   wr_addr, rd_addr;
   logic [EntryW-1:0] wr_data;

   // architectural state
   seq_type           seq_ff, seq_in;
   phase_type         phase_ff, phase_in;
   far_pend_type      pend_ff, pend_in;
   logic [LenW-1:0]   len_ff, len_in;
   logic [CountW-1:0] leaf_ff, leaf_in;
   logic [CountW-1:0] br_ff, br_in;
   logic [ByteW-1:0]  far_lo_ff, far_lo_in;
   logic [PtrW-1:0]   ptr_ff, ptr_in;
   logic [PixW-1:0]   pix_ff, pix_in;
   logic              ovf_ff, ovf_in;
   logic [ShiftW-1:0] shift_ff;
   logic [EntryW-1:0] root_ff;

   // walk sequencing
   logic [ByteW-1:0]  byte_ff, byte_in;
   logic [3:0]        bit_ff, bit_in;
   logic              chk_ff, chk_in;
   logic              cur_root_ff, cur_root_in;
   logic              far_second_ff, far_second_in;

   // response stage
   logic               out_valid_ff;
   logic [ColourW-1:0] out_colour_ff;
   logic [RepW-1:0]    out_count_ff;
   logic               out_last_ff;
   logic               out_ovf_ff;
   logic               emit;
   logic [ColourW-1:0] emit_colour;
   logic [RepW-1:0]    emit_count;
   logic               emit_last;
   logic               can_emit;

   // combinational scratch
   logic              restart;
   logic              put;
   logic [LenW-1:0]   e_len;
   logic [CountW-1:0] e_leaf, e_br;
   far_pend_type      e_pend;
   phase_type         e_phase;
   logic              e_ovf;
   logic [ByteW-1:0]  b;
   logic [JumpW-1:0]  far_jump, near_jump;
   logic [ShiftW-1:0] shift_eff;
   logic [PixW-1:0]   tile_pix;
   logic [PixW-1:0]   pix_next;
   logic              leaf_hit;
   logic              use_root;
   logic [EntryW-1:0] cur;
   logic [PtrW-1:0]   cur_ptr;
   logic [JumpW-1:0]  step;
   logic [17:0]       sum;
   logic [PtrW-1:0]   nptr;

   function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
      sat_inc = (v == CountMax) ? v : v + CountW'(1);
   endfunction

   // tile pixel count
   always_comb begin
      shift_eff = (shift_ff > ShiftMax) ? ShiftMax : shift_ff;
      tile_pix  = PixW'(PixMax) >> shift_eff;
      if (tile_pix == '0) begin
         tile_pix = PixW'(1);
      end
      pix_next = pix_ff + PixW'(1);
   end

   assign can_emit = !out_valid_ff || rsp_ready;

   // walk datapath
   always_comb begin
      leaf_hit = chk_ff && !rdata_ff[EntBranch];
      use_root = leaf_hit || (!chk_ff && cur_root_ff);
      cur      = use_root ? root_ff : rdata_ff;
      cur_ptr  = leaf_hit ? '0 : ptr_ff;
      if (byte_ff[bit_ff[2:0]]) begin
         step = cur[JumpW-1:0];
      end else begin
         step = cur[EntFar] ? JumpW'(3) : JumpW'(1);
      end
      sum = 18'(cur_ptr) + 18'(step);
      if (sum >= 18'(len_ff)) begin
         nptr = PtrW'(len_ff - LenW'(1));
      end else begin
         nptr = PtrW'(sum);
      end
   end

   // sequencer and load logic
   always_comb begin
      seq_in        = seq_ff;
      phase_in      = phase_ff;
      pend_in       = pend_ff;
      len_in        = len_ff;
      leaf_in       = leaf_ff;
      br_in         = br_ff;
      far_lo_in     = far_lo_ff;
      ptr_in        = ptr_ff;
      pix_in        = pix_ff;
      ovf_in        = ovf_ff;
      byte_in       = byte_ff;
      bit_in        = bit_ff;
      chk_in        = chk_ff;
      cur_root_in   = cur_root_ff;
      far_second_in = far_second_ff;
      q_pop         = 1'b0;
      put           = 1'b0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = nptr;
      emit          = 1'b0;
      emit_colour   = '0;
      emit_count    = RepW'(1);
      emit_last     = 1'b0;

      restart   = q_item.first_of_tile;
      b         = q_item.tile_byte;
      e_len     = restart ? '0 : len_ff;
      e_leaf    = restart ? '0 : leaf_ff;
      e_br      = restart ? '0 : br_ff;
      e_pend    = restart ? FP_NONE : pend_ff;
      e_phase   = restart ? PH_LOAD : phase_ff;
      e_ovf     = restart ? 1'b0 : ovf_ff;
      far_jump  = JumpW'(FarBase - 18'({b, far_lo_ff}));
      near_jump = JumpW'(NearBase - 9'(b));

      unique case (seq_ff)
         SQ_IDLE: begin
            if (q_valid && can_emit) begin
               q_pop    = 1'b1;
               len_in   = e_len;
               leaf_in  = e_leaf;
               br_in    = e_br;
               pend_in  = e_pend;
               phase_in = e_phase;
               ovf_in   = e_ovf;
               if (restart) begin
                  far_lo_in = '0;
                  ptr_in    = '0;
                  pix_in    = '0;
               end
               unique case (e_phase)
                  PH_LOAD: begin
                     if (e_pend == FP_LOW) begin
                        far_lo_in = b;
                        pend_in   = FP_HIGH;
                     end else if (e_pend == FP_HIGH) begin
                        put           = 1'b1;
                        wr_data       = {1'b1, 1'b1, far_jump};
                        br_in         = sat_inc(e_br);
                        pend_in       = FP_NONE;
                        far_second_in = 1'b0;
                        seq_in        = SQ_FAR;
                     end else if (b < FarMarker) begin
                        put     = 1'b1;
                        wr_data = EntryW'(b);
                        leaf_in = sat_inc(e_leaf);
                     end else if (b > FarMarker) begin
                        put     = 1'b1;
                        wr_data = {1'b1, 1'b0, near_jump};
                        br_in   = sat_inc(e_br);
                     end else begin
                        pend_in = FP_LOW;
                     end
                     if (put) begin
                        if (e_len < DepthLen) begin
                           len_in = e_len + LenW'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                     // codebook complete check (far branch completes later)
                     if (seq_in == SQ_IDLE && pend_in == FP_NONE && leaf_in > br_in) begin
                        if (br_in == '0) begin
                           emit        = 1'b1;
                           emit_colour = (e_len == '0) ? wr_data[ColourW-1:0]
                                                       : root_ff[ColourW-1:0];
                           emit_count  = RepW'(tile_pix);
                           emit_last   = 1'b1;
                           phase_in    = PH_DONE;
                        end else begin
                           phase_in    = PH_DECODE;
                           ptr_in      = '0;
                           cur_root_in = 1'b1;
                        end
                     end
                  end
                  PH_DECODE: begin
                     byte_in = b;
                     bit_in  = '0;
                     chk_in  = 1'b0;
                     seq_in  = SQ_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         SQ_FAR: begin
            // two colour-0 slots after a far branch
            put = 1'b1;
            if (len_ff < DepthLen) begin
               len_in = len_ff + LenW'(1);
            end else begin
               ovf_in = 1'b1;
            end
            far_second_in = 1'b1;
            if (far_second_ff) begin
               seq_in = SQ_IDLE;
               if (leaf_ff > br_ff) begin
                  phase_in    = PH_DECODE;
                  ptr_in      = '0;
                  cur_root_in = 1'b1;
               end
            end
         end
         SQ_WALK: begin
            if (!(leaf_hit && !can_emit)) begin
               if (leaf_hit) begin
                  emit        = 1'b1;
                  emit_colour = rdata_ff[ColourW-1:0];
                  emit_count  = RepW'(1);
                  emit_last   = (pix_next >= tile_pix);
                  pix_in      = pix_next;
                  ptr_in      = '0;
                  cur_root_in = 1'b1;
               end else if (chk_ff) begin
                  cur_root_in = 1'b0;
               end
               chk_in = 1'b0;
               if (emit_last) begin
                  phase_in = PH_DONE;
                  seq_in   = SQ_IDLE;
               end else if (bit_ff < 4'd8) begin
                  rd_en       = 1'b1;
                  ptr_in      = nptr;
                  chk_in      = 1'b1;
                  cur_root_in = 1'b0;
                  bit_in      = bit_ff + 4'd1;
               end else begin
                  seq_in = SQ_IDLE;
               end
            end
         end
         default: begin
            seq_in = SQ_IDLE;
         end
      endcase

      wr_en   = put && ((seq_ff == SQ_IDLE) ? (e_len < DepthLen) : (len_ff < DepthLen));
      wr_addr = (seq_ff == SQ_IDLE) ? PtrW'(e_len) : PtrW'(len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= SQ_IDLE;
         phase_ff      <= PH_LOAD;
         pend_ff       <= FP_NONE;
         len_ff        <= '0;
         leaf_ff       <= '0;
         br_ff         <= '0;
         far_lo_ff     <= '0;
         ptr_ff        <= '0;
         pix_ff        <= '0;
         ovf_ff        <= 1'b0;
         shift_ff      <= '0;
         bit_ff        <= '0;
         chk_ff        <= 1'b0;
         cur_root_ff   <= 1'b1;
         far_second_ff <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         phase_ff      <= phase_in;
         pend_ff       <= pend_in;
         len_ff        <= len_in;
         leaf_ff       <= leaf_in;
         br_ff         <= br_in;
         far_lo_ff     <= far_lo_in;
         ptr_ff        <= ptr_in;
         pix_ff        <= pix_in;
         ovf_ff        <= ovf_in;
         bit_ff        <= bit_in;
         chk_ff        <= chk_in;
         cur_root_ff   <= cur_root_in;
         far_second_ff <= far_second_in;
         if (csr_wr_en) begin
            shift_ff <= csr_wr_data;
         end
      end
   end

   // walked byte and root entry copy
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_colour_ff <= emit_colour;
         out_count_ff  <= emit_count;
         out_last_ff   <= emit_last;
         out_ovf_ff    <= ovf_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_colour_index      = out_colour_ff;
   assign rsp_repeat_count      = out_count_ff;
   assign rsp_last_of_tile      = out_last_ff;
   assign rsp_codebook_overflow = out_ovf_ff;

endmodule

// ----- hw/rtl/thd_checker.sv -----
// ----------------------------------------------------------------------------
// thd_checker
// Port-level checks of the decoder's response channel.
// ----------------------------------------------------------------------------
module thd_checker
   import thd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [ColourW-1:0] rsp_colour_index,
   input logic [RepW-1:0]    rsp_repeat_count,
   input logic               rsp_last_of_tile
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_colour_index)
         && $stable(rsp_repeat_count) && $stable(rsp_last_of_tile))
      else $error("stalled response changed");

   // a response never repeats zero pixels
   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != '0)
      else $error("zero repeat count");

   // a fill response always closes its tile
   a_fill_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repeat_count != RepW'(1) |-> rsp_last_of_tile)
      else $error("fill response without last_of_tile");

   // nothing offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind tile_huffman_tree_decoder thd_checker u_thd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_colour_index (rsp_colour_index),
   .rsp_repeat_count (rsp_repeat_count),
   .rsp_last_of_tile (rsp_last_of_tile)
);
